>>> hw/rtl/qr_segment_decoder_core_assert.svh
// Assertion macros used by the decoder top level.
`ifndef QR_SEGMENT_DECODER_CORE_ASSERT_SVH
`define QR_SEGMENT_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qrsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qrsd assertion failed");

`endif

>>> hw/rtl/qrsd_pkg.sv
package qrsd_pkg;

	// Result kinds, also used as the segment mode.
	localparam logic [1:0] KIND_NUM   = 2'd0;
	localparam logic [1:0] KIND_ALNUM = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;
	localparam logic [1:0] KIND_KANJI = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_CHAR  = 2'd0;
	localparam logic [1:0] ST_END   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Mode field codes of the bitstream.
	localparam logic [3:0] MODE_NUMERIC = 4'd1;
	localparam logic [3:0] MODE_ALNUM   = 4'd2;
	localparam logic [3:0] MODE_BYTE    = 4'd4;
	localparam logic [3:0] MODE_KANJI   = 4'd8;

	// Field widths in bits.
	localparam logic [3:0] W_MODE      = 4'd4;
	localparam logic [3:0] W_CNT_NUM   = 4'd10;
	localparam logic [3:0] W_CNT_ALNUM = 4'd9;
	localparam logic [3:0] W_CNT_OTHER = 4'd8;
	localparam logic [3:0] W_NUM3      = 4'd10;
	localparam logic [3:0] W_NUM2      = 4'd7;
	localparam logic [3:0] W_NUM1      = 4'd4;
	localparam logic [3:0] W_ALNUM2    = 4'd11;
	localparam logic [3:0] W_ALNUM1    = 4'd6;
	localparam logic [3:0] W_BYTE      = 4'd8;
	localparam logic [3:0] W_KANJI     = 4'd13;

	// Largest legal group values.
	localparam logic [12:0] MAX_NUM3   = 13'd999;
	localparam logic [12:0] MAX_NUM2   = 13'd99;
	localparam logic [12:0] MAX_NUM1   = 13'd9;
	localparam logic [12:0] MAX_ALNUM2 = 13'd2024;
	localparam logic [12:0] MAX_ALNUM1 = 13'd44;

	// Reciprocal multipliers for division by constants on bounded values.
	localparam logic [12:0] RECIP_100 = 13'd5243;  // v < 1024, shift 19
	localparam logic [7:0]  RECIP_10  = 8'd205;    // v < 1024, shift 11
	localparam logic [12:0] RECIP_45  = 13'd5826;  // v < 2048, shift 18
	localparam logic [12:0] ALNUM_BASE = 13'd45;
	localparam logic [12:0] DEC_BASE   = 13'd10;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_MODE  = 2'd0,
		PH_COUNT = 2'd1,
		PH_DATA  = 2'd2
	} phase_t;

	// What the back end does with one completed field.
	typedef enum logic [2:0] {
		OP_END    = 3'd0,
		OP_CHAR   = 3'd1,
		OP_RANGE  = 3'd2,
		OP_NUM3   = 3'd3,
		OP_NUM2   = 3'd4,
		OP_ALNUM2 = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  kind;
		logic [12:0] value;
	} job_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [12:0] value;
		logic [1:0]  status;
	} result_t;

endpackage

>>> hw/rtl/qrsd_front.sv
module qrsd_front import qrsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [3:0]  nibble,
	input  logic        first,
	output logic        job_valid,
	output job_t        job
);

	logic [12:0] buf_q;
	logic [3:0]  held_q;
	phase_t      phase_q;
	logic [1:0]  mode_q;
	logic [9:0]  left_q;
	logic        done_q;

	logic [12:0] w_buf;
	logic [3:0]  w_held;
	phase_t      w_phase;
	logic [1:0]  w_mode;
	logic [9:0]  w_left;
	logic        w_done;
	logic [12:0] w_v;
	logic [9:0]  w_used;

	// Width of the field now being gathered.
	function automatic logic [3:0] field_width(phase_t ph, logic [1:0] md, logic [9:0] lf);
		logic [3:0] w;
		w = W_MODE;
		unique case (ph)
			PH_COUNT: begin
				unique case (md)
					KIND_NUM:   w = W_CNT_NUM;
					KIND_ALNUM: w = W_CNT_ALNUM;
					default:    w = W_CNT_OTHER;
				endcase
			end
			PH_DATA: begin
				unique case (md)
					KIND_NUM:   w = (lf >= 10'd3) ? W_NUM3 : ((lf == 10'd2) ? W_NUM2 : W_NUM1);
					KIND_ALNUM: w = (lf >= 10'd2) ? W_ALNUM2 : W_ALNUM1;
					KIND_BYTE:  w = W_BYTE;
					default:    w = W_KANJI;
				endcase
			end
			default: w = W_MODE;
		endcase
		return w;
	endfunction

	// Shift the four bits in one by one; at most one field completes per nibble.
	always_comb begin
		w_buf     = first ? '0 : buf_q;
		w_held    = first ? '0 : held_q;
		w_phase   = first ? PH_MODE : phase_q;
		w_mode    = first ? KIND_NUM : mode_q;
		w_left    = first ? '0 : left_q;
		w_done    = first ? 1'b0 : done_q;
		w_v       = '0;
		w_used    = '0;
		job_valid = 1'b0;
		job.op    = OP_END;
		job.kind  = KIND_NUM;
		job.value = '0;
		for (int i = 3; i >= 0; i--) begin
			if (!w_done) begin
				w_buf  = {w_buf[11:0], nibble[2'(i)]};
				w_held = w_held + 4'd1;
				if (w_held >= field_width(w_phase, w_mode, w_left)) begin
					w_v    = w_buf;
					w_buf  = '0;
					w_held = '0;
					unique case (w_phase)
						PH_COUNT: begin
							w_left  = w_v[9:0];
							w_phase = (w_left == 10'd0) ? PH_MODE : PH_DATA;
						end
						PH_DATA: begin
							job_valid = 1'b1;
							job.kind  = w_mode;
							job.value = w_v;
							job.op    = OP_CHAR;
							w_used    = 10'd1;
							unique case (w_mode)
								KIND_NUM: begin
									if (w_left >= 10'd3) begin
										w_used = 10'd3;
										job.op = (w_v > MAX_NUM3) ? OP_RANGE : OP_NUM3;
									end else if (w_left == 10'd2) begin
										w_used = 10'd2;
										job.op = (w_v > MAX_NUM2) ? OP_RANGE : OP_NUM2;
									end else begin
										job.op = (w_v > MAX_NUM1) ? OP_RANGE : OP_CHAR;
									end
								end
								KIND_ALNUM: begin
									if (w_left >= 10'd2) begin
										w_used = 10'd2;
										job.op = (w_v > MAX_ALNUM2) ? OP_RANGE : OP_ALNUM2;
									end else begin
										job.op = (w_v > MAX_ALNUM1) ? OP_RANGE : OP_CHAR;
									end
								end
								default: job.op = OP_CHAR;
							endcase
							w_left = (w_left > w_used) ? (w_left - w_used) : '0;
							if (w_left == 10'd0) begin
								w_phase = PH_MODE;
							end
						end
						default: begin
							unique case (w_v[3:0])
								MODE_NUMERIC: begin
									w_mode  = KIND_NUM;
									w_phase = PH_COUNT;
								end
								MODE_ALNUM: begin
									w_mode  = KIND_ALNUM;
									w_phase = PH_COUNT;
								end
								MODE_BYTE: begin
									w_mode  = KIND_BYTE;
									w_phase = PH_COUNT;
								end
								MODE_KANJI: begin
									w_mode  = KIND_KANJI;
									w_phase = PH_COUNT;
								end
								default: begin
									job_valid = 1'b1;
									job.op    = OP_END;
									job.kind  = KIND_NUM;
									job.value = '0;
									w_done    = 1'b1;
									w_phase   = PH_MODE;
								end
							endcase
						end
					endcase
				end
			end
		end
	end

	// Parser state advances on every accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			held_q  <= '0;
			phase_q <= PH_MODE;
			mode_q  <= KIND_NUM;
			left_q  <= '0;
			done_q  <= 1'b0;
		end else if (take) begin
			buf_q   <= w_buf;
			held_q  <= w_held;
			phase_q <= w_phase;
			mode_q  <= w_mode;
			left_q  <= w_left;
			done_q  <= w_done;
		end
	end

endmodule

>>> hw/rtl/qrsd_queue.sv
module qrsd_queue import qrsd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_data,
	output logic full,
	input  logic rd_en,
	output job_t rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/qrsd_back.sv
module qrsd_back import qrsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  job_t        q_data,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [12:0] value,
	output logic [1:0]  status,
	output logic        last
);

	// Stage 1: the job with its quotients.
	logic        valid_s1;
	job_t        job_s1;
	logic [3:0]  q100_s1;
	logic [6:0]  q10_s1;
	logic [5:0]  q45_s1;

	// Stage 2: the expanded results, delivered one per cycle while pop is high.
	logic        valid_s2;
	result_t     ent_s2 [3];
	logic [1:0]  cnt_s2;
	logic [1:0]  idx_s2;

	logic [22:0] p100;
	logic [17:0] p10;
	logic [23:0] p45;
	result_t     ent_n [3];
	logic [1:0]  cnt_n;
	logic        is_last;
	logic        s2_free;
	logic        s1_ready;

	// Handshake between the stages.
	assign is_last  = (idx_s2 == cnt_s2 - 2'd1);
	assign s2_free  = !valid_s2 || (pop && is_last);
	assign s1_ready = !valid_s1 || s2_free;
	assign q_pop    = !q_empty && s1_ready;

	// Division by 100, 10 and 45 through reciprocal multiplication.
	assign p100 = 23'(q_data.value[9:0]) * 23'(RECIP_100);
	assign p10  = 18'(q_data.value[9:0]) * 18'(RECIP_10);
	assign p45  = 24'(q_data.value[10:0]) * 24'(RECIP_45);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1  <= q_data;
			q100_s1 <= p100[22:19];
			q10_s1  <= p10[17:11];
			q45_s1  <= p45[23:18];
		end
	end

	// Remainders and the list of results for one job.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ent_n[i].kind   = job_s1.kind;
			ent_n[i].value  = job_s1.value;
			ent_n[i].status = ST_CHAR;
		end
		cnt_n = 2'd1;
		unique case (job_s1.op)
			OP_END: begin
				ent_n[0].status = ST_END;
			end
			OP_RANGE: begin
				ent_n[0].status = ST_RANGE;
			end
			OP_NUM3: begin
				cnt_n = 2'd3;
				ent_n[0].value = 13'(q100_s1);
				ent_n[1].value = 13'(q10_s1) - 13'(q100_s1) * DEC_BASE;
				ent_n[2].value = job_s1.value - 13'(q10_s1) * DEC_BASE;
			end
			OP_NUM2: begin
				cnt_n = 2'd2;
				ent_n[0].value = 13'(q10_s1);
				ent_n[1].value = job_s1.value - 13'(q10_s1) * DEC_BASE;
			end
			OP_ALNUM2: begin
				cnt_n = 2'd2;
				ent_n[0].value = 13'(q45_s1);
				ent_n[1].value = job_s1.value - 13'(q45_s1) * ALNUM_BASE;
			end
			default: begin
				cnt_n = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
			idx_s2   <= '0;
		end else if (pop) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			ent_s2 <= ent_n;
			cnt_s2 <= cnt_n;
		end
	end

	// Result channel.
	assign empty  = !valid_s2;
	assign kind   = ent_s2[idx_s2].kind;
	assign value  = ent_s2[idx_s2].value;
	assign status = ent_s2[idx_s2].status;
	assign last   = is_last;

endmodule

>>> hw/rtl/qr_segment_decoder_core.sv
// QR code data segment decoder, versions 1 to 9.
// Input channel: the bitstream arrives one nibble per item, most significant bit
// first, with first set on the first nibble of a new bitstream. An item is taken
// at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on kind, value,
// status and last; pop high at a clock edge takes it. last marks the final
// result caused by one nibble; a nibble that completes no data field or end mark gives none.
// A job passes through the job queue and the expansion stages before its results can be popped.
// Throughput: one nibble per cycle is taken while full is low; results leave at
// one per cycle while pop is high, so a three-digit numeric group, which gives
// three results, holds the result port longest and the result port sets the
// sustained rate for numeric data.
// Reset clears the parser state and all queued work; the block is ready as soon
// as reset is released. When the receiver stalls, the job queue of QUEUE_DEPTH
// entries fills and full rises until pop resumes.
`include "qr_segment_decoder_core_assert.svh"

module qr_segment_decoder_core import qrsd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  nibble,
	input  logic        first,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [12:0] value,
	output logic [1:0]  status,
	output logic        last
);

	logic take;
	logic job_valid;
	job_t job;
	job_t q_data;
	logic q_empty;
	logic q_pop;

	assign take = push && !full;

	// Parser: gathers fields and classifies completed groups.
	qrsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.nibble    (nibble),
		.first     (first),
		.job_valid (job_valid),
		.job       (job)
	);

	// Job queue between parser and result expansion.
	qrsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take && job_valid),
		.wr_data (job),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// Expansion of jobs into results.
	qrsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.kind    (kind),
		.value   (value),
		.status  (status),
		.last    (last)
	);

	// An end result carries no character and closes its nibble.
	`QRSD_ASSERT_SAME(a_end_shape, clk, arst_n, !empty && status == ST_END, kind == KIND_NUM && value == 13'd0 && last)
	// Decimal digits stay below ten.
	`QRSD_ASSERT_SAME(a_digit_range, clk, arst_n, !empty && status == ST_CHAR && kind == KIND_NUM, value <= MAX_NUM1)
	// Alphanumeric indices stay below forty-five.
	`QRSD_ASSERT_SAME(a_alnum_range, clk, arst_n, !empty && status == ST_CHAR && kind == KIND_ALNUM, value <= MAX_ALNUM1)
	// A result that is not the last of its nibble is followed by another one.
	`QRSD_ASSERT_NEXT(a_group_cont, clk, arst_n, !empty && pop && !last, !empty)

endmodule
